>>> src/exptok_pkg.sv
// Shared types and constants for the expression tokenizer.
package exptok_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int DEPTH_BITS_DEF = 16;
  localparam int TOKEN_VALUE_W = 32;

  typedef enum logic [2:0] {
    PK_NONE = 3'd0,
    PK_NUM  = 3'd1,
    PK_STAR = 3'd2,
    PK_LT   = 3'd3,
    PK_GT   = 3'd4
  } pend_t;

  typedef enum logic [4:0] {
    K_NUM   = 5'd0,
    K_LPAR  = 5'd1,
    K_RPAR  = 5'd2,
    K_PLUS  = 5'd3,
    K_MINUS = 5'd4,
    K_TIMES = 5'd5,
    K_DIV   = 5'd6,
    K_MOD   = 5'd7,
    K_AND   = 5'd8,
    K_OR    = 5'd9,
    K_XOR   = 5'd10,
    K_NOT   = 5'd11,
    K_POW   = 5'd12,
    K_LSL   = 5'd13,
    K_LSR   = 5'd14,
    K_END   = 5'd15,
    K_NONE  = 5'd16
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_ANGLE    = 3'd1,
    E_SURPLUS  = 3'd2,
    E_UNEXP    = 3'd3,
    E_UNCLOSED = 3'd4
  } err_t;

  typedef struct packed {
    kind_t                           kind;
    logic signed [TOKEN_VALUE_W-1:0] value;
    err_t                            err;
    logic                            seen;
    logic                            last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] count;
  } lex_out_t;

endpackage

>>> src/exptok_if.sv
// Handshake interfaces for the character and token channels.
interface exptok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface exptok_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         token_kind;
  logic signed [31:0] token_value;
  logic [2:0]         error_code;
  logic               error_seen;
  logic               last;
  modport source (output valid, output token_kind, output token_value, output error_code,
                  output error_seen, output last, input ready);
  modport sink (input valid, input token_kind, input token_value, input error_code,
                input error_seen, input last, output ready);
endinterface

>>> src/exptok_lexer.sv
// Lexer state and the per-character token logic.
module exptok_lexer #(
  parameter int VALUE_BITS = exptok_pkg::VALUE_BITS_DEF,
  parameter int DEPTH_BITS = exptok_pkg::DEPTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [7:0]           char_code,
  output exptok_pkg::lex_out_t lex
);
  import exptok_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  pend_t                  pk, pk_next;
  logic [VALUE_BITS-1:0]  pv, pv_next;
  logic [DEPTH_BITS-1:0]  depth, depth_next;
  logic                   ef, ef_next;

  logic [63:0]            pv_wide;
  logic [3:0]             digit;
  logic [VALUE_BITS-1:0]  digit_ext;
  logic                   is_digit;
  logic                   op_valid;
  kind_t                  op_kind;

  logic                   fl_valid;
  res_t                   fl;
  logic                   use_flush;
  logic                   f_used;
  logic                   tv;
  res_t                   tok;
  logic                   clear_all;

  assign pv_wide   = 64'(pv);
  assign digit     = 4'(char_code - CH_0);
  assign digit_ext = VALUE_BITS'(digit);
  assign is_digit  = (char_code >= CH_0) && (char_code <= CH_9);

  always_comb begin
    op_valid = 1'b1;
    op_kind  = K_NONE;
    unique case (char_code)
      CH_PLUS:  op_kind = K_PLUS;
      CH_MINUS: op_kind = K_MINUS;
      CH_SLASH: op_kind = K_DIV;
      CH_PCT:   op_kind = K_MOD;
      CH_AMP:   op_kind = K_AND;
      CH_BAR:   op_kind = K_OR;
      CH_CARET: op_kind = K_XOR;
      CH_TILDE: op_kind = K_NOT;
      default:  op_valid = 1'b0;
    endcase
  end

  always_comb begin
    fl_valid = (pk != PK_NONE);
    fl.value = '0;
    fl.err   = E_NONE;
    fl.seen  = 1'b0;
    fl.last  = 1'b0;
    unique case (pk)
      PK_NUM: begin
        fl.kind  = K_NUM;
        fl.value = pv_wide[TOKEN_VALUE_W-1:0];
      end
      PK_STAR: fl.kind = K_TIMES;
      PK_LT, PK_GT: begin
        fl.kind = K_NONE;
        fl.err  = E_ANGLE;
      end
      default: fl.kind = K_NONE;
    endcase
  end

  always_comb begin
    pk_next    = pk;
    pv_next    = pv;
    depth_next = depth;
    use_flush  = 1'b0;
    clear_all  = 1'b0;
    tv         = 1'b0;
    tok.kind   = K_NONE;
    tok.value  = '0;
    tok.err    = E_NONE;
    tok.seen   = 1'b0;
    tok.last   = 1'b1;
    priority if (is_digit) begin
      if (pk == PK_NUM) begin
        pv_next = (pv << 3) + (pv << 1) + digit_ext;
      end else begin
        use_flush = 1'b1;
        pk_next   = PK_NUM;
        pv_next   = digit_ext;
      end
    end else if (char_code == CH_LPAR) begin
      use_flush  = 1'b1;
      pk_next    = PK_NONE;
      pv_next    = '0;
      tv         = 1'b1;
      tok.kind   = K_LPAR;
      depth_next = depth + DEPTH_BITS'(1);
    end else if (char_code == CH_RPAR) begin
      use_flush  = 1'b1;
      pk_next    = PK_NONE;
      pv_next    = '0;
      tv         = 1'b1;
      tok.kind   = K_RPAR;
      depth_next = depth - DEPTH_BITS'(1);
      tok.err    = depth_next[DEPTH_BITS-1] ? E_SURPLUS : E_NONE;
    end else if (char_code == CH_STAR) begin
      pv_next = '0;
      if (pk == PK_STAR) begin
        pk_next  = PK_NONE;
        tv       = 1'b1;
        tok.kind = K_POW;
      end else begin
        use_flush = 1'b1;
        pk_next   = PK_STAR;
      end
    end else if (char_code == CH_LT) begin
      pv_next = '0;
      if (pk == PK_LT) begin
        pk_next  = PK_NONE;
        tv       = 1'b1;
        tok.kind = K_LSL;
      end else begin
        use_flush = 1'b1;
        pk_next   = PK_LT;
      end
    end else if (char_code == CH_GT) begin
      pv_next = '0;
      if (pk == PK_GT) begin
        pk_next  = PK_NONE;
        tv       = 1'b1;
        tok.kind = K_LSR;
      end else begin
        use_flush = 1'b1;
        pk_next   = PK_GT;
      end
    end else if (char_code == CH_SPACE || char_code == CH_TAB ||
                 char_code == CH_CR || char_code == CH_LF) begin
      use_flush = 1'b1;
      pk_next   = PK_NONE;
      pv_next   = '0;
    end else if (char_code == CH_NUL) begin
      use_flush = 1'b1;
      clear_all = 1'b1;
      tv        = 1'b1;
      tok.kind  = K_END;
      tok.value = TOKEN_VALUE_W'(signed'(depth));
      tok.err   = (depth != '0 && !depth[DEPTH_BITS-1]) ? E_UNCLOSED : E_NONE;
      pk_next    = PK_NONE;
      pv_next    = '0;
      depth_next = '0;
    end else if (op_valid) begin
      use_flush = 1'b1;
      pk_next   = PK_NONE;
      pv_next   = '0;
      tv        = 1'b1;
      tok.kind  = op_kind;
    end else begin
      tv       = 1'b1;
      tok.kind = K_NONE;
      tok.err  = E_UNEXP;
    end
  end

  // The flushed token goes first and the current token second; the sticky
  // flag includes each result's own error.
  always_comb begin
    f_used    = use_flush && fl_valid;
    lex.r1      = tok;
    lex.r1.seen = ef || (f_used && fl.err != E_NONE) || (tok.err != E_NONE);
    lex.r1.last = 1'b1;
    if (f_used) begin
      lex.r0      = fl;
      lex.r0.seen = ef || (fl.err != E_NONE);
      lex.r0.last = !tv;
    end else begin
      lex.r0      = tok;
      lex.r0.seen = ef || (tok.err != E_NONE);
      lex.r0.last = 1'b1;
    end
    lex.count = {1'b0, f_used} + {1'b0, tv};
    ef_next   = clear_all ? 1'b0 :
                (ef || (f_used && fl.err != E_NONE) || (tv && tok.err != E_NONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk    <= PK_NONE;
      pv    <= '0;
      depth <= '0;
      ef    <= 1'b0;
    end else if (go) begin
      pk    <= pk_next;
      pv    <= pv_next;
      depth <= depth_next;
      ef    <= ef_next;
    end
  end

`ifndef SYNTH
  a_idle_value_zero: assert property (@(posedge clk) disable iff (rst)
    (pk == PK_NONE) |-> (pv == '0))
    else $error("pending value nonzero with nothing pending");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (go && char_code == CH_NUL) |=> (depth == '0 && !ef && pk == PK_NONE))
    else $error("end of expression did not clear the lexer state");
`endif

endmodule

>>> src/exptok_outbuf.sv
// Result register with a spill slot for characters that yield two tokens.
module exptok_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  exptok_pkg::lex_out_t lex,
  output logic                 can_take,
  exptok_out_if.source         tokens
);
  import exptok_pkg::*;

  logic out_valid;
  logic sp_valid;
  res_t out_data;
  res_t sp_data;
  logic pop;

  assign pop      = out_valid && tokens.ready;
  assign can_take = !sp_valid && (!out_valid || tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sp_valid  <= 1'b0;
    end else if (push) begin
      out_valid <= (lex.count != 2'd0);
      sp_valid  <= (lex.count == 2'd2);
    end else if (pop) begin
      out_valid <= sp_valid;
      sp_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= lex.r0;
      sp_data  <= lex.r1;
    end else if (pop) begin
      out_data <= sp_data;
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.token_kind  = out_data.kind;
  assign tokens.token_value = out_data.value;
  assign tokens.error_code  = out_data.err;
  assign tokens.error_seen  = out_data.seen;
  assign tokens.last        = out_data.last;

`ifndef SYNTH
  a_spill_behind_head: assert property (@(posedge clk) disable iff (rst)
    sp_valid |-> (out_valid && !out_data.last))
    else $error("spill slot holds a token without a non-final head");
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.err != E_NONE) |-> out_data.seen)
    else $error("error reported without the sticky flag");
`endif

endmodule

>>> src/expression_tokenizer.sv
// A character's first token is registered in the output buffer after the input
// staging register. Throughput: one character per cycle while the output is
// ready; a second token waits in the spill slot and stalls input until sent.
// Characters that yield no token produce no transfer.
// Reset is synchronous and clears the pending token, depth and error flag.
module expression_tokenizer #(
  parameter int VALUE_BITS = exptok_pkg::VALUE_BITS_DEF,
  parameter int DEPTH_BITS = exptok_pkg::DEPTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  exptok_in_if.sink    chars,
  exptok_out_if.source tokens
);
  import exptok_pkg::*;

  logic       stg_valid;
  logic [7:0] stg_char;
  logic       can_take;
  logic       go;
  lex_out_t   lex;

  assign go          = stg_valid && can_take;
  assign chars.ready = !stg_valid || can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (chars.ready) begin
      stg_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      stg_char <= chars.char_code;
    end
  end

  exptok_lexer #(
    .VALUE_BITS(VALUE_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .char_code (stg_char),
    .lex       (lex)
  );

  exptok_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (go),
    .lex      (lex),
    .can_take (can_take),
    .tokens   (tokens)
  );

endmodule
